// ===== sv/spq_pkg.sv =====
// Shared types and constants for the sorted-insert priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  // Default geometry of the key store.
  localparam int unsigned DepthDef    = 16;
  localparam int unsigned KeyWidthDef = 32;

  // Fixed widths of the request and response fields.
  localparam int unsigned KeyFieldW  = 32;
  localparam int unsigned FillFieldW = 5;

  // Request mode codes.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // Command broadcast from the top level to every cell of the row.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_cmd_t;

endpackage

// ===== sv/spq_if.sv =====
// Request and response channel interfaces of the sorted-insert priority queue.
`timescale 1ns / 1ps

interface spq_req_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic signed [spq_pkg::KeyFieldW-1:0] key;

  modport source (output valid, output mode, output key, input ready);
  modport sink   (input valid, input mode, input key, output ready);
endinterface

interface spq_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  ok;
  logic signed [spq_pkg::KeyFieldW-1:0]  removed_key;
  logic signed [spq_pkg::KeyFieldW-1:0]  front_key;
  logic                                  is_empty;
  logic        [spq_pkg::FillFieldW-1:0] fill_count;

  modport source (output valid, output ok, output removed_key, output front_key,
                  output is_empty, output fill_count, input ready);
  modport sink   (input valid, input ok, input removed_key, input front_key,
                  input is_empty, input fill_count, output ready);
endinterface

// ===== sv/spq_cell.sv =====
// One storage cell of the sorted key row: holds a key and shifts with its neighbors.
`timescale 1ns / 1ps

module spq_cell #(
  parameter int unsigned KEY_WIDTH = spq_pkg::KeyWidthDef,
  parameter int unsigned CNT_W     = 5,
  parameter int unsigned INDEX     = 0
) (
  input  logic                        clk_i,
  input  spq_pkg::cell_cmd_t          cmd_i,
  input  logic [CNT_W-1:0]            count_i,
  input  logic signed [KEY_WIDTH-1:0] new_key_i,
  input  logic signed [KEY_WIDTH-1:0] left_key_i,
  input  logic                        left_ge_i,
  input  logic signed [KEY_WIDTH-1:0] right_key_i,
  output logic signed [KEY_WIDTH-1:0] key_o,
  output logic                        ge_o
);
  import spq_pkg::*;

  logic signed [KEY_WIDTH-1:0] key_q, key_d;
  logic                        occupied;

  // A cell holds a key when its place lies below the fill count.
  assign occupied = (count_i > CNT_W'(INDEX));

  // The insert position is the first empty cell or the first key not below the new one.
  assign ge_o = !occupied || (key_q >= new_key_i);

  // Remove shifts toward the front; insert opens a gap at the insert position.
  always_comb begin
    key_d = key_q;
    if (cmd_i.rem) begin
      key_d = right_key_i;
    end else if (cmd_i.ins) begin
      if (left_ge_i) begin
        key_d = left_key_i;
      end else if (ge_o) begin
        key_d = new_key_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

// ===== sv/sorted_insert_priority_queue.sv =====
// Latency: a result appears in the cycle after its request is accepted.
// Throughput: one request per cycle while the result side is not stalled; the whole cell row shifts at once.
// A new request is taken while the previous result waits, once that result is taken.
// Reset clears the fill count and the result valid; stored keys are not cleared.
// Top level of the sorted-insert priority queue built as a row of shifting cells.
`timescale 1ns / 1ps

module sorted_insert_priority_queue #(
  parameter int unsigned DEPTH     = spq_pkg::DepthDef,
  parameter int unsigned KEY_WIDTH = spq_pkg::KeyWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]             count_q, count_d;
  logic                        accept;
  logic                        full, empty;
  cell_cmd_t                   cmd;
  logic signed [KEY_WIDTH-1:0] new_key;
  logic [KeyFieldW+KEY_WIDTH-1:0] key_in_ext;

  logic signed [KEY_WIDTH-1:0] cell_key [DEPTH];
  logic                        cell_ge  [DEPTH];

  logic                        rsp_valid_q;
  logic                        ok_q, ok_d;
  logic [KEY_WIDTH-1:0]        removed_q, removed_d;
  logic [KEY_WIDTH-1:0]        front_q, front_d;
  logic [CntW-1:0]             fill_q;
  logic [KeyFieldW+KEY_WIDTH-1:0] removed_ext, front_ext;
  logic [FillFieldW+CntW-1:0]     fill_ext;

  // Request handshake: taken when the output stage is free or being emptied.
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign full  = (count_q == CntW'(DEPTH));
  assign empty = (count_q == '0);

  // Key field reduced or sign-extended to the stored key width.
  assign key_in_ext = {{KEY_WIDTH{req_i.key[KeyFieldW-1]}}, req_i.key};
  assign new_key    = key_in_ext[KEY_WIDTH-1:0];

  // Command to the cell row; refused operations leave the store alone.
  always_comb begin
    cmd.ins = accept && (req_i.mode == MODE_INSERT) && !full;
    cmd.rem = accept && (req_i.mode == MODE_REMOVE) && !empty;
  end

  // Fill count update.
  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Row of cells; each cell talks only to its two neighbors.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [KEY_WIDTH-1:0] left_key, right_key;
    logic                        left_ge;

    if (i == 0) begin : g_head
      assign left_key = new_key;
      assign left_ge  = 1'b0;
    end else begin : g_body
      assign left_key = cell_key[i-1];
      assign left_ge  = cell_ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_key = cell_key[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    spq_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .CNT_W     (CntW),
      .INDEX     (i)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .count_i     (count_q),
      .new_key_i   (new_key),
      .left_key_i  (left_key),
      .left_ge_i   (left_ge),
      .right_key_i (right_key),
      .key_o       (cell_key[i]),
      .ge_o        (cell_ge[i])
    );
  end

  // Result fields: the front is the head cell's next value, or zero if the store ends empty.
  always_comb begin
    ok_d      = cmd.ins || cmd.rem;
    removed_d = cmd.rem ? cell_key[0] : '0;
    front_d   = cell_key[0];
    if (cmd.rem) begin
      front_d = cell_key[1];
    end else if (cmd.ins && cell_ge[0]) begin
      front_d = new_key;
    end
    if (count_d == '0) begin
      front_d = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q      <= ok_d;
      removed_q <= removed_d;
      front_q   <= front_d;
      fill_q    <= count_d;
    end
  end

  // Keys leave zero-extended from the key width; the count wraps to its field.
  assign removed_ext = {{KeyFieldW{1'b0}}, removed_q};
  assign front_ext   = {{KeyFieldW{1'b0}}, front_q};
  assign fill_ext    = {{FillFieldW{1'b0}}, fill_q};

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.ok          = ok_q;
  assign rsp_o.removed_key = removed_ext[KeyFieldW-1:0];
  assign rsp_o.front_key   = front_ext[KeyFieldW-1:0];
  assign rsp_o.is_empty    = (fill_q == '0);
  assign rsp_o.fill_count  = fill_ext[FillFieldW-1:0];

endmodule

// ===== sv/spq_checker.sv =====
// Port-level checker for the sorted-insert priority queue and its bind.
`timescale 1ns / 1ps

module spq_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  rsp_valid_i,
  input logic                                  rsp_ready_i,
  input logic                                  rsp_ok_i,
  input logic signed [spq_pkg::KeyFieldW-1:0]  rsp_removed_key_i,
  input logic signed [spq_pkg::KeyFieldW-1:0]  rsp_front_key_i,
  input logic                                  rsp_is_empty_i,
  input logic        [spq_pkg::FillFieldW-1:0] rsp_fill_count_i
);
  import spq_pkg::*;

  // A stalled result stays on the port.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_front_key_i))
    else $error("response dropped or changed while stalled");

  // The empty flag agrees with the fill count.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_is_empty_i == (rsp_fill_count_i == '0)))
    else $error("empty flag disagrees with fill count");

  // A refused request reports no removed key.
  a_removed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ok_i |-> rsp_removed_key_i == '0)
    else $error("removed key set on a refused request");

  // An empty store shows a zero front key.
  a_front_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_is_empty_i |-> rsp_front_key_i == '0)
    else $error("front key set on an empty store");

endmodule

bind sorted_insert_priority_queue spq_checker u_spq_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_ok_i          (rsp_o.ok),
  .rsp_removed_key_i (rsp_o.removed_key),
  .rsp_front_key_i   (rsp_o.front_key),
  .rsp_is_empty_i    (rsp_o.is_empty),
  .rsp_fill_count_i  (rsp_o.fill_count)
);

// ===== test/sorted_insert_priority_queue_tb.sv =====
// Self-checking testbench for the sorted-insert priority queue with a shadow key store.
`timescale 1ns / 1ps

module sorted_insert_priority_queue_tb;

  localparam int unsigned QueueDepth = spq_pkg::DepthDef;
  localparam int unsigned KeyW       = spq_pkg::KeyFieldW;
  localparam int unsigned FillW      = spq_pkg::FillFieldW;
  localparam int unsigned RandItems  = 1230;
  localparam int unsigned QuietItems = 150;
  localparam int unsigned LongHold   = 80;

  // One response as the block should report it.
  typedef struct {
    logic                   ok;
    logic signed [KeyW-1:0] removed_key;
    logic signed [KeyW-1:0] front_key;
    logic                   is_empty;
    logic [FillW-1:0]       fill_count;
  } queue_status_t;

  // Shadow copy of the sorted key store and the responses still owed by the block.
  class sorted_key_shadow;
    logic signed [KeyW-1:0] shadow_keys[QueueDepth];
    int unsigned            key_count;
    queue_status_t          owed_status[$];
    int unsigned            mismatches;

    function new();
      key_count   = 0;
      mismatches  = 0;
    endfunction

    // Applies an accepted request to the shadow store and records its response.
    function void take_request(logic mode, logic signed [KeyW-1:0] key);
      queue_status_t st;
      int unsigned   pos;
      st.ok          = 1'b0;
      st.removed_key = '0;
      if (mode == spq_pkg::MODE_INSERT) begin
        if (key_count < QueueDepth) begin
          pos = 0;
          // The new key goes in front of the first key that is not smaller.
          while (pos < key_count && shadow_keys[pos] < key) pos++;
          for (int unsigned i = key_count; i > pos; i--) shadow_keys[i] = shadow_keys[i-1];
          shadow_keys[pos] = key;
          key_count++;
          st.ok = 1'b1;
        end
      end else begin
        if (key_count > 0) begin
          st.removed_key = shadow_keys[0];
          for (int unsigned i = 1; i < key_count; i++) shadow_keys[i-1] = shadow_keys[i];
          key_count--;
          st.ok = 1'b1;
        end
      end
      st.front_key  = (key_count > 0) ? shadow_keys[0] : '0;
      st.is_empty   = (key_count == 0);
      st.fill_count = key_count[FillW-1:0];
      owed_status.push_back(st);
    endfunction

    // Compares a taken response with the oldest owed one, field by field.
    function void check_response(queue_status_t got);
      queue_status_t exp;
      if (owed_status.size() == 0) begin
        $display("%0t: response with no request waiting: ok=%0b front=%0d", $time,
                 got.ok, got.front_key);
        mismatches++;
        return;
      end
      exp = owed_status.pop_front();
      if (got.ok !== exp.ok) begin
        $display("%0t: ok expected %0b actual %0b", $time, exp.ok, got.ok);
        mismatches++;
      end
      if (got.removed_key !== exp.removed_key) begin
        $display("%0t: removed_key expected %0d actual %0d", $time, exp.removed_key,
                 got.removed_key);
        mismatches++;
      end
      if (got.front_key !== exp.front_key) begin
        $display("%0t: front_key expected %0d actual %0d", $time, exp.front_key,
                 got.front_key);
        mismatches++;
      end
      if (got.is_empty !== exp.is_empty) begin
        $display("%0t: is_empty expected %0b actual %0b", $time, exp.is_empty, got.is_empty);
        mismatches++;
      end
      if (got.fill_count !== exp.fill_count) begin
        $display("%0t: fill_count expected %0d actual %0d", $time, exp.fill_count,
                 got.fill_count);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  sorted_key_shadow shadow = new();

  // Shared between the sender and the receiver processes.
  bit quiet_run;
  bit hold_asked;

  sorted_insert_priority_queue #(
    .DEPTH    (QueueDepth),
    .KEY_WIDTH(spq_pkg::KeyWidthDef)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  // Free-running clock.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Offers one request and waits until the block takes it.
  task automatic send_request(logic mode, logic signed [KeyW-1:0] key);
    req_ch.valid <= 1'b1;
    req_ch.mode  <= mode;
    req_ch.key   <= key;
    do @(posedge clk_i); while (!req_ch.ready);
    shadow.take_request(mode, key);
    // Random idle burst on the request side.
    if (!quiet_run && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // Picks a key: full-range half the time, else extremes or a narrow band for ties.
  function automatic logic signed [KeyW-1:0] pick_key();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: return {1'b1, {(KeyW-1){1'b0}}};
          1: return {1'b0, {(KeyW-1){1'b1}}};
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2: return $signed(KeyW'($urandom_range(0, 7))) - 4;
      default: return $urandom;
    endcase
  endfunction

  // Takes responses and stalls the response side at random.
  initial begin
    int unsigned   stall_left;
    queue_status_t got;
    stall_left   = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        got.ok          = rsp_ch.ok;
        got.removed_key = rsp_ch.removed_key;
        got.front_key   = rsp_ch.front_key;
        got.is_empty    = rsp_ch.is_empty;
        got.fill_count  = rsp_ch.fill_count;
        shadow.check_response(got);
      end
      if (hold_asked) begin
        hold_asked = 1'b0;
        stall_left = LongHold;
      end
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else if (!quiet_run && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Main sequence: reset, directed requests, random requests, drain.
  initial begin
    logic signed [KeyW-1:0] fill_keys[16];
    int unsigned            insert_pct;
    fill_keys = '{32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sd1, 32'sd1, 32'sh7fffffff,
                  32'sh80000000, 32'sd5, 32'sd5, -32'sd5, 32'sd100, -32'sd100,
                  32'sh40000000, 32'shc0000000, 32'sd3, 32'sd2};
    quiet_run    = 1'b0;
    hold_asked   = 1'b0;
    rst_ni       = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.mode  = spq_pkg::MODE_INSERT;
    req_ch.key   = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Remove from an empty store is refused.
    send_request(spq_pkg::MODE_REMOVE, 32'sh12345678);
    // Fill the store with extremes and ties.
    foreach (fill_keys[i]) send_request(spq_pkg::MODE_INSERT, fill_keys[i]);
    // Insert into a full store is dropped.
    send_request(spq_pkg::MODE_INSERT, -32'sd7);
    repeat (4) send_request(spq_pkg::MODE_REMOVE, '1);

    // Random requests in segments whose insert share pushes the fill level around.
    insert_pct = 50;
    for (int unsigned n = 0; n < RandItems; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 85;
          1: insert_pct = 50;
          default: insert_pct = 15;
        endcase
      end
      // Long receiver hold-off while requests keep coming.
      if (n == 300) hold_asked = 1'b1;
      // Sender pause until every owed response has arrived.
      if (n == 600) begin
        req_ch.valid <= 1'b0;
        do @(posedge clk_i); while (shadow.owed_status.size() != 0);
      end
      if (n == RandItems - QuietItems) quiet_run = 1'b1;
      send_request(($urandom_range(1, 100) <= insert_pct) ? spq_pkg::MODE_INSERT
                                                           : spq_pkg::MODE_REMOVE,
                   pick_key());
    end
    req_ch.valid <= 1'b0;

    // Drain, then wait for any stray response.
    while (shadow.owed_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (shadow.mismatches == 0) begin
      $display("sorted_insert_priority_queue_tb: PASS");
    end else begin
      $display("sorted_insert_priority_queue_tb: FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("sorted_insert_priority_queue_tb: FAIL");
    $finish;
  end

endmodule
